// File: rtl/cca_pkg.sv
// Shared widths, defaults and types for the contiguous chunk allocator.
`default_nettype none

package cca_pkg;

    // Field widths of the channels
    localparam int KIND_W       = 1;
    localparam int REQ_BYTES_W  = 16;
    localparam int START_W      = 6;
    localparam int COUNT_W      = 7;
    localparam int POOL_W       = 7;
    localparam int RUN_START_W  = 6;
    localparam int RUN_LEN_W    = 7;
    localparam int USED_BYTES_W = 15;

    // Defaults for the top-level parameters
    localparam int NUM_CHUNKS_DEF  = 64;
    localparam int CHUNK_BYTES_DEF = 256;

    // Pool register after reset
    localparam logic [POOL_W-1:0] POOL_RESET = 7'd64;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    // Broadcast from the controller to every cell
    typedef struct packed {
        t_kind kind;   // mode of the wave now running
        logic  mark;   // set busy over [lo, hi]
    } t_cmd;

    // Flags that travel with the scan wave
    typedef struct packed {
        logic go;      // wave front is here
        logic hit;     // a run has been found below this cell
        logic stop;    // free met a chunk that was already free
    } t_wave_flags;

endpackage

`default_nettype wire

// File: rtl/cca_if.sv
// Valid/ready channel interfaces: request, response and pool configuration.
`default_nettype none

interface cca_req_if
    import cca_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [REQ_BYTES_W-1:0] request_bytes;
    logic [START_W-1:0]     start_index;
    logic [COUNT_W-1:0]     chunk_count;

    modport source (output valid, kind, request_bytes, start_index, chunk_count,
                    input ready);
    modport sink   (input valid, kind, request_bytes, start_index, chunk_count,
                    output ready);
endinterface

interface cca_rsp_if
    import cca_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic [RUN_START_W-1:0]  run_start;
    logic [RUN_LEN_W-1:0]    run_length;
    logic [USED_BYTES_W-1:0] used_bytes;

    modport source (output valid, ok, run_start, run_length, used_bytes,
                    input ready);
    modport sink   (input valid, ok, run_start, run_length, used_bytes,
                    output ready);
endinterface

interface cca_cfg_if
    import cca_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [POOL_W-1:0] pool_chunks;

    modport source (output valid, pool_chunks, input ready);
    modport sink   (input valid, pool_chunks, output ready);
endinterface

`default_nettype wire

// File: rtl/cca_cell.sv
// One chunk of the busy map plus its stage of the scan wave.
`default_nettype none

module cca_cell
    import cca_pkg::*;
#(
    parameter int NUM_CHUNKS  = NUM_CHUNKS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int CELL_IDX    = 0
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire t_cmd                               i_cmd,
    input  wire logic [$clog2(NUM_CHUNKS)-1:0]      i_lo,
    input  wire logic [$clog2(NUM_CHUNKS)-1:0]      i_hi,
    input  wire logic [$clog2(NUM_CHUNKS+1)-1:0]    i_pool,
    input  wire logic [REQ_BYTES_W-1:0]             i_bytes,
    input  wire t_wave_flags                        i_flags,
    input  wire logic [$clog2(NUM_CHUNKS+1)-1:0]    i_run,
    input  wire logic [$clog2(NUM_CHUNKS*CHUNK_BYTES+1)-1:0] i_rbytes,
    input  wire logic [$clog2(NUM_CHUNKS)-1:0]      i_end,
    output t_wave_flags                             o_flags,
    output logic [$clog2(NUM_CHUNKS+1)-1:0]         o_run,
    output logic [$clog2(NUM_CHUNKS*CHUNK_BYTES+1)-1:0] o_rbytes,
    output logic [$clog2(NUM_CHUNKS)-1:0]           o_end
);

    localparam int IW   = $clog2(NUM_CHUNKS);
    localparam int CW   = $clog2(NUM_CHUNKS + 1);
    localparam int BW   = $clog2(NUM_CHUNKS * CHUNK_BYTES + 1);
    localparam int CMPW = (BW > REQ_BYTES_W) ? BW : REQ_BYTES_W;

    logic          r_busy,  n_busy;
    t_wave_flags   r_flags, n_flags;
    logic [CW-1:0] r_run,   n_run;
    logic [BW-1:0] r_rb,    n_rb;
    logic [IW-1:0] r_end,   n_end;

    logic          in_pool;
    logic          in_range;
    logic [BW-1:0] rb_sum;

    assign in_pool  = CW'(CELL_IDX) < i_pool;
    assign in_range = (IW'(CELL_IDX) >= i_lo) && (IW'(CELL_IDX) <= i_hi);
    assign rb_sum   = i_rbytes + BW'(CHUNK_BYTES);

    always_comb begin
        n_busy  = r_busy;
        n_flags = i_flags;
        n_run   = i_run;
        n_rb    = i_rbytes;
        n_end   = i_end;
        if (i_flags.go) begin
            if (i_cmd.kind == KIND_ALLOC) begin
                // run is frozen once found further down
                if (!i_flags.hit) begin
                    if (r_busy || !in_pool) begin
                        n_run = '0;
                        n_rb  = '0;
                    end else begin
                        n_run = i_run + CW'(1);
                        n_rb  = rb_sum;
                        // shortest run whose bytes exceed the request
                        if (CMPW'(rb_sum) > CMPW'(i_bytes)) begin
                            n_flags.hit = 1'b1;
                            n_end       = IW'(CELL_IDX);
                        end
                    end
                end
            end else begin
                // free: run counts cleared chunks
                if (in_range && !i_flags.stop) begin
                    if (r_busy) begin
                        n_busy = 1'b0;
                        n_run  = i_run + CW'(1);
                    end else begin
                        n_flags.stop = 1'b1;
                    end
                end
            end
        end
        if (i_cmd.mark && in_range) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_flags <= '0;
        end else begin
            r_busy  <= n_busy;
            r_flags <= n_flags;
        end
        r_run <= n_run;
        r_rb  <= n_rb;
        r_end <= n_end;
    end

    assign o_flags  = r_flags;
    assign o_run    = r_run;
    assign o_rbytes = r_rb;
    assign o_end    = r_end;

endmodule

`default_nettype wire

// File: rtl/contiguous_chunk_allocator.sv
// Top level of the contiguous chunk allocator: controller and row of map cells.
//
//  channel  | dir | transaction payload
//  ---------+-----+--------------------------------------------------------
//  i_req    | in  | kind, request_bytes, start_index, chunk_count
//  o_rsp    | out | ok, run_start, run_length, used_bytes
//  i_cfg    | in  | pool_chunks (always ready)
//
//  Scanning: an accepted request launches a scan wave that moves one cell per
//  cycle along the row, and the tail's outcome is captured in the result
//  registers. The next request is taken once the finish state hands them on.
//  A free with a bad range or a zero count skips the scan.
//  Reset: every chunk free at once (one flip-flop per cell), used count 0,
//  pool 64. A result waiting in o_rsp does not block the next accept; a new
//  result waits in the finish state until the output register drains.
`default_nettype none

module contiguous_chunk_allocator
    import cca_pkg::*;
#(
    parameter int NUM_CHUNKS  = NUM_CHUNKS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cca_req_if.sink    i_req,
    cca_rsp_if.source  o_rsp,
    cca_cfg_if.sink    i_cfg
);

    localparam int IW = $clog2(NUM_CHUNKS);
    localparam int CW = $clog2(NUM_CHUNKS + 1);
    localparam int BW = $clog2(NUM_CHUNKS * CHUNK_BYTES + 1);
    localparam int PW = (CW > POOL_W) ? CW : POOL_W;
    localparam int FW = PW + 1;
    localparam int MW = CW + $clog2(CHUNK_BYTES + 1);
    localparam int UW = (MW > USED_BYTES_W) ? MW : USED_BYTES_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                  r_state;
    logic [POOL_W-1:0]       r_pool;
    t_kind                   r_kind;
    logic [REQ_BYTES_W-1:0]  r_bytes;
    logic [IW-1:0]           r_lo;
    logic [IW-1:0]           r_hi;
    logic                    r_launch;
    logic                    r_mark;
    logic [CW-1:0]           r_used;
    logic                    r_ok;
    logic [IW-1:0]           r_start;
    logic [CW-1:0]           r_len;

    logic                    r_out_valid;
    logic                    r_out_ok;
    logic [RUN_START_W-1:0]  r_out_start;
    logic [RUN_LEN_W-1:0]    r_out_len;
    logic [USED_BYTES_W-1:0] r_out_bytes;

    // Effective pool: the register clamped to the map size
    logic [CW-1:0] pool_eff;
    logic [FW-1:0] free_end;
    logic          free_bad;
    logic          req_acc;
    logic [UW-1:0] used_prod;

    // Scan wave between the cells; index NUM_CHUNKS is the tail of the row
    t_cmd        w_cmd;
    t_wave_flags w_flags [0:NUM_CHUNKS];
    logic [CW-1:0] w_run [0:NUM_CHUNKS];
    logic [BW-1:0] w_rb  [0:NUM_CHUNKS];
    logic [IW-1:0] w_end [0:NUM_CHUNKS];

    assign pool_eff = (PW'(r_pool) > PW'(NUM_CHUNKS)) ? CW'(NUM_CHUNKS) : CW'(r_pool);
    assign free_end = FW'(i_req.start_index) + FW'(i_req.chunk_count);
    assign free_bad = free_end > FW'(pool_eff);
    assign req_acc  = i_req.valid && i_req.ready;
    assign used_prod = UW'(r_used) * UW'(CHUNK_BYTES);

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_out_ok;
    assign o_rsp.run_start  = r_out_start;
    assign o_rsp.run_length = r_out_len;
    assign o_rsp.used_bytes = r_out_bytes;

    // Head of the wave: launched in the cycle after accept
    assign w_cmd      = '{kind: r_kind, mark: r_mark};
    assign w_flags[0] = '{go: r_launch, hit: 1'b0, stop: 1'b0};
    assign w_run[0]   = '0;
    assign w_rb[0]    = '0;
    assign w_end[0]   = '0;

    for (genvar g = 0; g < NUM_CHUNKS; g++) begin : g_cell
        cca_cell #(
            .NUM_CHUNKS  (NUM_CHUNKS),
            .CHUNK_BYTES (CHUNK_BYTES),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (w_cmd),
            .i_lo     (r_lo),
            .i_hi     (r_hi),
            .i_pool   (pool_eff),
            .i_bytes  (r_bytes),
            .i_flags  (w_flags[g]),
            .i_run    (w_run[g]),
            .i_rbytes (w_rb[g]),
            .i_end    (w_end[g]),
            .o_flags  (w_flags[g+1]),
            .o_run    (w_run[g+1]),
            .o_rbytes (w_rb[g+1]),
            .o_end    (w_end[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pool      <= POOL_RESET;
            r_launch    <= 1'b0;
            r_mark      <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            r_mark   <= 1'b0;

            if (i_cfg.valid && i_cfg.ready) begin
                r_pool <= i_cfg.pool_chunks;
            end

            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_kind  <= t_kind'(i_req.kind);
                        r_bytes <= i_req.request_bytes;
                        r_lo    <= IW'(i_req.start_index);
                        r_hi    <= IW'(free_end - FW'(1));
                        r_ok    <= 1'b0;
                        r_start <= '0;
                        r_len   <= '0;
                        if (t_kind'(i_req.kind) == KIND_ALLOC) begin
                            r_launch <= 1'b1;
                            r_state  <= S_SCAN;
                        end else if (free_bad) begin
                            // range leaves the pool: fail, nothing touched
                            r_state <= S_FINISH;
                        end else if (i_req.chunk_count == '0) begin
                            r_ok    <= 1'b1;
                            r_state <= S_FINISH;
                        end else begin
                            r_launch <= 1'b1;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // tail of the row carries the outcome
                    if (w_flags[NUM_CHUNKS].go) begin
                        r_state <= S_FINISH;
                        if (r_kind == KIND_FREE) begin
                            r_used <= r_used - w_run[NUM_CHUNKS];
                            r_ok   <= !w_flags[NUM_CHUNKS].stop;
                        end else if (w_flags[NUM_CHUNKS].hit) begin
                            r_lo    <= w_end[NUM_CHUNKS] - IW'(w_run[NUM_CHUNKS] - CW'(1));
                            r_hi    <= w_end[NUM_CHUNKS];
                            r_mark  <= 1'b1;
                            r_used  <= r_used + w_run[NUM_CHUNKS];
                            r_ok    <= 1'b1;
                            r_start <= w_end[NUM_CHUNKS] - IW'(w_run[NUM_CHUNKS] - CW'(1));
                            r_len   <= w_run[NUM_CHUNKS];
                        end
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_ok    <= r_ok;
                        r_out_start <= RUN_START_W'(r_start);
                        r_out_len   <= RUN_LEN_W'(r_len);
                        r_out_bytes <= used_prod[USED_BYTES_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_contiguous_chunk_allocator.sv
// Self-checking testbench for the contiguous chunk allocator.
module tb_contiguous_chunk_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import cca_pkg::*;

    // Run limits and pressure settings
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = NUM_CHUNKS_DEF + 16;

    // One request transaction as the sender offers it
    typedef struct packed {
        t_kind                  kind;
        logic [REQ_BYTES_W-1:0] request_bytes;
        logic [START_W-1:0]     start_index;
        logic [COUNT_W-1:0]     chunk_count;
    } t_alloc_req;

    // One response transaction, field for field as on o_rsp
    typedef struct packed {
        logic                    ok;
        logic [RUN_START_W-1:0]  run_start;
        logic [RUN_LEN_W-1:0]    run_length;
        logic [USED_BYTES_W-1:0] used_bytes;
    } t_alloc_rsp;

    logic i_clk;
    logic i_rst_n;

    cca_req_if req_if ();
    cca_rsp_if rsp_if ();
    cca_cfg_if cfg_if ();

    contiguous_chunk_allocator #(
        .NUM_CHUNKS  (NUM_CHUNKS_DEF),
        .CHUNK_BYTES (CHUNK_BYTES_DEF)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the allocator: busy map, busy count and pool register.
    logic [NUM_CHUNKS_DEF-1:0] chunk_busy;
    int                        busy_chunk_count;
    int                        pool_setting;

    // Responses still owed by the block, oldest first
    t_alloc_rsp pending_rsp_q[$];

    // Bookkeeping
    int mismatch_count;
    int cycle_count;
    int req_count;
    int alloc_req_count;
    int free_req_count;
    int grant_count;
    int rsp_checked;

    // Sender burst control
    int burst_left;
    bit tight_offer;

    // Receiver stall control; hold-off requests are counted, not flagged,
    // so only the ready process ever writes its own countdown.
    int holdoff_asked;
    int holdoff_served;
    int holdoff_left;
    int stall_seg_left;
    int stall_mode;
    logic [15:0] stall_pattern;

    // Clock: 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_rsp_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Pool size as the block sees it: register values past the map clamp to it.
    function automatic int effective_pool();
        return (pool_setting > NUM_CHUNKS_DEF) ? NUM_CHUNKS_DEF : pool_setting;
    endfunction

    // Predict the response to one accepted request and advance the shadow state.
    // Allocate: first fit over adjacent free chunks inside the pool.
    // Free: range check first, then clear in order until a chunk is already free.
    task automatic compute_allocator_response(input t_alloc_req r, output t_alloc_rsp e);
        int  pool;
        int  need;
        int  run;
        int  start;
        int  first;
        int  cnt;
        int  i;
        bit  found;
        bit  stop;
        pool  = effective_pool();
        e     = '0;
        found = 1'b0;
        stop  = 1'b0;
        run   = 0;
        start = 0;
        if (r.kind == KIND_ALLOC) begin
            need = int'(r.request_bytes) / CHUNK_BYTES_DEF + 1;
            if (need <= pool) begin
                for (i = 0; i < pool && !found; i++) begin
                    if (chunk_busy[i]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == need) begin
                            found = 1'b1;
                            start = i + 1 - need;
                        end
                    end
                end
            end
            if (found) begin
                for (i = start; i < start + need; i++)
                    chunk_busy[i] = 1'b1;
                busy_chunk_count += need;
                e.ok         = 1'b1;
                e.run_start  = RUN_START_W'(start);
                e.run_length = RUN_LEN_W'(need);
            end
        end else begin
            first = int'(r.start_index);
            cnt   = int'(r.chunk_count);
            if (first + cnt <= pool) begin
                e.ok = 1'b1;
                for (i = first; i < first + cnt && !stop; i++) begin
                    if (!chunk_busy[i]) begin
                        e.ok = 1'b0;
                        stop = 1'b1;
                    end else begin
                        chunk_busy[i] = 1'b0;
                        busy_chunk_count--;
                    end
                end
            end
        end
        e.used_bytes = USED_BYTES_W'(busy_chunk_count * CHUNK_BYTES_DEF);
    endtask

    function automatic t_alloc_req alloc_req(input int bytes);
        t_alloc_req r;
        r               = '0;
        r.kind          = KIND_ALLOC;
        r.request_bytes = REQ_BYTES_W'(bytes);
        return r;
    endfunction

    function automatic t_alloc_req free_req(input int first, input int cnt);
        t_alloc_req r;
        r             = '0;
        r.kind        = KIND_FREE;
        r.start_index = START_W'(first);
        r.chunk_count = COUNT_W'(cnt);
        return r;
    endfunction

    // Random request. Most frees target a real busy run so the map churns;
    // the rest are noise ranges (bad range, zero count, already-free chunks).
    // Unused fields carry random bits so they toggle too.
    function automatic t_alloc_req make_random_request();
        t_alloc_req r;
        int  pool;
        int  pick;
        int  sub;
        int  base;
        int  idx;
        int  len;
        int  k;
        bit  found;
        pool            = effective_pool();
        r.kind          = KIND_ALLOC;
        r.request_bytes = REQ_BYTES_W'($urandom);
        r.start_index   = START_W'($urandom);
        r.chunk_count   = COUNT_W'($urandom);
        pick            = $urandom_range(0, 99);
        found           = 1'b0;
        idx             = 0;
        if (pick >= 45 && pick < 80 && pool > 0) begin
            base = $urandom_range(0, pool - 1);
            for (k = 0; k < pool && !found; k++) begin
                idx = (base + k) % pool;
                if (chunk_busy[idx])
                    found = 1'b1;
            end
        end
        if (found) begin
            len = 0;
            while (idx + len < pool && chunk_busy[idx + len])
                len++;
            r.kind        = KIND_FREE;
            r.start_index = START_W'(idx);
            // occasionally run past the busy run to hit a free chunk
            if ($urandom_range(0, 9) == 0)
                r.chunk_count = COUNT_W'(len + $urandom_range(1, 3));
            else
                r.chunk_count = COUNT_W'($urandom_range(1, len));
        end else if (pick >= 80) begin
            r.kind = KIND_FREE;
            if ($urandom_range(0, 3) == 0)
                r.chunk_count = COUNT_W'($urandom_range(0, 127));
            else
                r.chunk_count = COUNT_W'($urandom_range(0, pool + 2));
        end else begin
            sub = $urandom_range(0, 9);
            case (sub)
                0, 1, 2, 3, 4: r.request_bytes = REQ_BYTES_W'($urandom_range(0, 2047));
                5, 6: begin
                    // straddle a chunk boundary
                    k = $urandom_range(1, 8);
                    r.request_bytes = REQ_BYTES_W'(k * CHUNK_BYTES_DEF - $urandom_range(0, 1));
                end
                7:       r.request_bytes = REQ_BYTES_W'($urandom_range(0, 16383));
                8:       r.request_bytes = REQ_BYTES_W'($urandom);
                default: r.request_bytes = REQ_BYTES_W'($urandom_range(0, 255));
            endcase
        end
        return r;
    endfunction

    // Offer one request and wait for its transaction. Requests go out in
    // bursts; between bursts valid drops for a random gap (often zero).
    task automatic send_request(input t_alloc_req r);
        int         gap;
        t_alloc_rsp e;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (tight_offer)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(15, 40);
            else
                gap = $urandom_range(0, 6);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_if.valid         <= 1'b1;
        req_if.kind          <= r.kind;
        req_if.request_bytes <= r.request_bytes;
        req_if.start_index   <= r.start_index;
        req_if.chunk_count   <= r.chunk_count;
        do @(posedge i_clk); while (!req_if.ready);
        compute_allocator_response(r, e);
        pending_rsp_q.push_back(e);
        req_count++;
        if (r.kind == KIND_ALLOC)
            alloc_req_count++;
        else
            free_req_count++;
        if (r.kind == KIND_ALLOC && e.ok)
            grant_count++;
    endtask

    // Drop valid and wait until every owed response has come back.
    task automatic wait_until_idle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(negedge i_clk);
        burst_left = 0;
    endtask

    // Pool register write; only ever issued with the block idle.
    task automatic write_pool(input int value);
        wait_until_idle();
        @(negedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.pool_chunks <= POOL_W'(value);
        do @(posedge i_clk); while (!cfg_if.ready);
        pool_setting = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        repeat (2) @(negedge i_clk);
    endtask

    task automatic run_random_items(input int n);
        repeat (n) send_request(make_random_request());
    endtask

    // Receiver ready: segments of always-ready, a rotating stall pattern, or
    // coin-flip stalls, with the long hold-off taking priority when asked.
    always @(negedge i_clk) begin
        if (holdoff_served != holdoff_asked) begin
            holdoff_served = holdoff_asked;
            holdoff_left   = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            if (stall_seg_left == 0) begin
                stall_seg_left = $urandom_range(20, 300);
                stall_mode     = $urandom_range(0, 2);
                stall_pattern  = 16'($urandom) | 16'h0001;
            end
            stall_seg_left--;
            case (stall_mode)
                0: rsp_if.ready <= 1'b1;
                1: begin
                    rsp_if.ready  <= stall_pattern[0];
                    stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
                end
                default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Response checker: every response transaction is matched against the
    // oldest prediction, all four fields at once.
    always @(posedge i_clk) begin
        t_alloc_rsp got;
        t_alloc_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.ok         = rsp_if.ok;
            got.run_start  = rsp_if.run_start;
            got.run_length = rsp_if.run_length;
            got.used_bytes = rsp_if.used_bytes;
            if (pending_rsp_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"mismatch #%0d: response with none outstanding: ",
                              "ok=%0b start=%0d len=%0d used=%0d"},
                             mismatch_count, got.ok, got.run_start, got.run_length,
                             got.used_bytes);
            end else begin
                want = pending_rsp_q.pop_front();
                rsp_checked++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch #%0d: expected ok=%0b start=%0d len=%0d ",
                                  "used=%0d, got ok=%0b start=%0d len=%0d used=%0d"},
                                 mismatch_count, want.ok, want.run_start, want.run_length,
                                 want.used_bytes, got.ok, got.run_start, got.run_length,
                                 got.used_bytes);
                end
            end
        end
    end

    // Field extremes and the corner cases at the default pool of 64:
    // hole too small for a two-chunk run, zero-count free, range past the
    // pool end, free stopping at an already-free chunk, oversize request,
    // full pool and allocate with no room.
    task automatic test_directed_edges();
        send_request(alloc_req(0));
        send_request(alloc_req(255));
        send_request(alloc_req(256));
        send_request(alloc_req(511));
        send_request(free_req(1, 1));
        send_request(alloc_req(256));     // one-chunk hole must be skipped
        send_request(alloc_req(0));       // fills that hole
        send_request(free_req(0, 0));
        send_request(free_req(63, 2));
        send_request(free_req(60, 4));
        send_request(free_req(4, 6));     // frees some, then meets a free chunk
        send_request(alloc_req(65535));
        send_request(free_req(0, 4));
        send_request(free_req(0, 64));
        send_request(alloc_req(16383));   // whole pool
        send_request(alloc_req(0));       // no room left
        send_request(free_req(0, 64));
        send_request(free_req(63, 1));
        send_request(alloc_req(16128));
        send_request(free_req(0, 127));
        send_request(free_req(0, 64));
        wait_until_idle();
    endtask

    // Pool register at its extremes: one chunk, empty, and above the map size.
    task automatic test_pool_extremes();
        write_pool(1);
        send_request(alloc_req(0));
        send_request(alloc_req(0));
        send_request(alloc_req(256));
        send_request(free_req(0, 1));
        send_request(free_req(0, 2));
        write_pool(0);
        send_request(alloc_req(0));
        send_request(free_req(0, 0));
        send_request(free_req(0, 1));
        write_pool(127);
        send_request(alloc_req(16383));
        send_request(free_req(1, 64));
        send_request(free_req(0, 64));
        write_pool(100);
        run_random_items(10);
        wait_until_idle();
    endtask

    // Shrink the pool under busy chunks: they stay busy, keep counting in
    // used bytes and cannot be freed until the pool grows again.
    task automatic test_pool_shrink();
        write_pool(64);
        repeat (6) send_request(alloc_req(2047));
        write_pool(16);
        send_request(free_req(20, 4));
        send_request(free_req(0, 4));
        send_request(alloc_req(0));
        send_request(alloc_req(1024));
        run_random_items(20);
        write_pool(64);
        run_random_items(20);
        wait_until_idle();
    endtask

    // Bulk random traffic over several pool sizes.
    task automatic test_random_traffic();
        write_pool(64);
        run_random_items(300);
        write_pool(37);
        run_random_items(200);
        write_pool(100);
        run_random_items(150);
        write_pool(8);
        run_random_items(120);
        write_pool(2);
        run_random_items(60);
        write_pool(64);
        run_random_items(120);
        wait_until_idle();
    endtask

    // Receiver holds off while the sender keeps offering back to back, so
    // the output register and finish state fill and the request side stalls.
    task automatic test_backpressure();
        @(posedge i_clk);
        holdoff_asked++;
        tight_offer = 1'b1;
        run_random_items(16);
        tight_offer = 1'b0;
        wait_until_idle();
    endtask

    initial begin
        // every input known from time zero
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.kind          = KIND_ALLOC;
        req_if.request_bytes = '0;
        req_if.start_index   = '0;
        req_if.chunk_count   = '0;
        rsp_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.pool_chunks   = '0;

        chunk_busy       = '0;
        busy_chunk_count = 0;
        pool_setting     = int'(POOL_RESET);
        mismatch_count   = 0;
        cycle_count      = 0;
        req_count        = 0;
        alloc_req_count  = 0;
        free_req_count   = 0;
        grant_count      = 0;
        rsp_checked      = 0;
        burst_left       = 0;
        tight_offer      = 1'b0;
        holdoff_asked    = 0;
        holdoff_served   = 0;
        holdoff_left     = 0;
        stall_seg_left   = 0;
        stall_mode       = 0;
        stall_pattern    = 16'h0001;

        // single synchronous reset at the start
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_directed_edges();
        test_pool_extremes();
        test_pool_shrink();
        test_backpressure();
        test_random_traffic();

        // let anything stray surface before the verdict
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_rsp_q.size() != 0) begin
            mismatch_count += pending_rsp_q.size();
            $display("%0d responses never arrived", pending_rsp_q.size());
        end

        $display({"Run covered %0d requests (%0d allocate, %0d free), %0d grants, ",
                  "%0d responses checked"},
                 req_count, alloc_req_count, free_req_count, grant_count, rsp_checked);
        $display({"Pool sizes 0, 1, 2, 8, 16, 37, 64, 100, 127; one %0d-cycle ",
                  "receiver hold-off; %0d mismatches"},
                 HOLDOFF_CYCLES, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
